// ===== rtl/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, codes and constants of the integer to ASCII digit converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

   // Conversion mode codes
   localparam logic [1:0] OP_UDEC  = 2'd0;
   localparam logic [1:0] OP_SDEC  = 2'd1;
   localparam logic [1:0] OP_RADIX = 2'd2;

   // Quotient bits produced per divider cycle
   localparam int STEP_BITS = 4;

   localparam logic [4:0] RADIX_RESET = 5'd16;
   localparam logic [4:0] RADIX_DEC   = 5'd10;
   localparam logic [4:0] RADIX_MIN   = 5'd2;
   localparam logic [4:0] RADIX_MAX   = 5'd16;

   localparam logic [7:0] CHAR_MINUS   = 8'h2D;  // '-'
   localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;  // 'a'
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'
   localparam logic [3:0] DIGIT_NINE   = 4'd9;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;   // latch a new word, clear digit count
      logic sign;   // push '-' into the output pipe
      logic step;   // one divider cycle
      logic emit;   // read one stored digit, most significant first
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic op_ok;      // request opcode is a defined mode
      logic neg;        // signed mode with negative operand
      logic step_last;  // this divider cycle finishes a digit
      logic quot_zero;  // quotient after this cycle is zero
      logic emit_last;  // this read fetches the final digit
   } status_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] c;
      if (d <= DIGIT_NINE) begin
         c = CHAR_ZERO + {4'd0, d};
      end else begin
         c = (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + {4'd0, d} - 8'd10;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/integer_to_ascii_digits_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_core
// Converts one binary word to ASCII digits (unsigned/signed decimal or a
// configured radix), most significant character first.
// ----------------------------------------------------------------------------
//
//   channel   handshake               payload
//   -------   ---------------------   -------------------------------------
//   request   start & !busy           req_value, req_opcode, req_upper_case
//   response  rsp_strobe (1 cycle)    rsp_character, rsp_last
//   csr       csr_valid & csr_ready   csr_data (radix)
//
// A word with d digits keeps busy high through its division and read-out;
//   NUM_W is VALUE_WIDTH rounded up to a multiple of 4 and divided down once
//   per digit. Decimal: d <= 10; radix 2 at 64 bits: d <= 64. The divider
//   loop takes 4 quotient bits a cycle.
// Each digit-store read and each '-' passes the read stage and the character
//   register before it leaves. Opcode 3 is accepted and yields nothing.
// Reset: synchronous, clears the sequencer, output strobe and radix (16).
// The receiver cannot stall; each character is on the ports for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_digits_core
   import itoa_pkg::*;
#(
   parameter int VALUE_WIDTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request
   input  wire logic        start,
   output logic             busy,
   input  wire logic [63:0] req_value,
   input  wire logic [1:0]  req_opcode,
   input  wire logic        req_upper_case,
   // response
   output logic             rsp_strobe,
   output logic [7:0]       rsp_character,
   output logic             rsp_last,
   // radix register write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [4:0]  csr_data
);

   cmd_type    cmd;
   status_type status;
   logic [4:0] radix_ff;

   // radix register; always writable; the user must write it only while idle, the block does not enforce this
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_valid && csr_ready) begin
         radix_ff <= csr_data;
      end
   end

   itoa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   itoa_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req_value),
      .req_opcode     (req_opcode),
      .req_upper_case (req_upper_case),
      .radix          (radix_ff),
      .cmd            (cmd),
      .status         (status),
      .rsp_strobe     (rsp_strobe),
      .rsp_character  (rsp_character),
      .rsp_last       (rsp_last)
   );

   // a defined opcode always starts a conversion
   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode == OP_UDEC || req_opcode == OP_SDEC ||
                          req_opcode == OP_RADIX)) |=> busy)
      else $error("defined opcode accepted but block not busy");

   // the unused opcode is dropped without any work
   a_bad_op_idle : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode != OP_UDEC && req_opcode != OP_SDEC &&
       req_opcode != OP_RADIX) |=> !busy)
      else $error("unused opcode started a conversion");

   // every character traces back to a busy cycle or a start behind the output pipe's read stage and character register
   a_strobe_src : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy || start, 2))
      else $error("character emitted without a conversion in flight");

endmodule

`default_nettype wire

// ===== rtl/itoa_ctrl.sv =====
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer: accept, divide digit by digit, then read digits back out.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_ctrl
   import itoa_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire status_type status,
   output cmd_type         cmd,
   output logic            busy
);

   typedef enum logic [1:0] {
      IDLE,
      DIVIDE,
      EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         IDLE: begin
            if (start && status.op_ok) begin
               cmd.load = 1'b1;
               cmd.sign = status.neg;
               state_in = DIVIDE;
            end
         end
         DIVIDE: begin
            cmd.step = 1'b1;
            if (status.step_last && status.quot_zero) begin
               state_in = EMIT;
            end
         end
         EMIT: begin
            cmd.emit = 1'b1;
            if (status.emit_last) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != IDLE);

endmodule

`default_nettype wire

// ===== rtl/itoa_dpath.sv =====
// ----------------------------------------------------------------------------
// itoa_dpath
// Radix divider (4 quotient bits a cycle), digit store, output pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_dpath
   import itoa_pkg::*;
#(
   parameter int VALUE_WIDTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [63:0] req_value,
   input  wire logic [1:0]  req_opcode,
   input  wire logic        req_upper_case,
   input  wire logic [4:0]  radix,
   input  wire cmd_type     cmd,
   output status_type       status,
   output logic             rsp_strobe,
   output logic [7:0]       rsp_character,
   output logic             rsp_last
);

   localparam int NUM_W  = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
   localparam int NSTEP  = NUM_W / STEP_BITS;
   localparam int SC_W   = $clog2(NSTEP);
   localparam int IDX_W  = $clog2(VALUE_WIDTH);
   localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);

   logic [NUM_W-1:0] num_ff, num_in, load_num;
   logic [3:0]       rem_ff, rem_in;
   logic [SC_W-1:0]  step_cnt_ff;
   logic             qnz_ff;
   logic [CNT_W-1:0] digit_cnt_ff;
   logic [4:0]       base_ff, base_in;
   logic             upper_ff;

   logic [3:0]       digit_mem [VALUE_WIDTH];
   logic [3:0]       mem_q_ff;
   logic [IDX_W-1:0] rd_addr;
   logic [CNT_W-1:0] cnt_dec;

   logic p1_valid_ff, p1_sign_ff, p1_last_ff;

   logic [STEP_BITS-1:0] qbits;
   logic [31:0]          low_word, mag_word;
   logic                 neg;

   // operand load
   assign low_word = req_value[31:0];
   assign neg      = (req_opcode == OP_SDEC) && low_word[31];
   assign mag_word = neg ? (~low_word + 32'd1) : low_word;

   always_comb begin
      if (req_opcode == OP_RADIX) begin
         load_num = NUM_W'(req_value[VALUE_WIDTH-1:0]);
         if (radix < RADIX_MIN) begin
            base_in = RADIX_MIN;
         end else if (radix > RADIX_MAX) begin
            base_in = RADIX_MAX;
         end else begin
            base_in = radix;
         end
      end else begin
         load_num = NUM_W'(mag_word);
         base_in  = RADIX_DEC;
      end
   end

   // restoring division, STEP_BITS bits of the dividend per cycle
   always_comb begin
      logic [4:0] r;
      logic [3:0] rm;
      rm = rem_ff;
      for (int k = 0; k < STEP_BITS; k++) begin
         r = {rm, num_ff[NUM_W-1-k]};
         qbits[STEP_BITS-1-k] = (r >= base_ff);
         rm = (r >= base_ff) ? 4'(r - base_ff) : r[3:0];
      end
      rem_in = rm;
      num_in = {num_ff[NUM_W-STEP_BITS-1:0], qbits};
   end

   assign cnt_dec = digit_cnt_ff - CNT_W'(1);
   assign rd_addr = cnt_dec[IDX_W-1:0];

   assign status.op_ok     = (req_opcode == OP_UDEC) || (req_opcode == OP_SDEC) ||
                             (req_opcode == OP_RADIX);
   assign status.neg       = neg;
   assign status.step_last = (step_cnt_ff == SC_W'(NSTEP - 1));
   assign status.quot_zero = !(qnz_ff || (|qbits));
   assign status.emit_last = (digit_cnt_ff == CNT_W'(1));

   // divider and digit count
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         num_ff       <= load_num;
         rem_ff       <= '0;
         step_cnt_ff  <= '0;
         qnz_ff       <= 1'b0;
         digit_cnt_ff <= '0;
         base_ff      <= base_in;
         upper_ff     <= (req_opcode == OP_RADIX) && req_upper_case;
      end else if (cmd.step) begin
         num_ff <= num_in;
         if (status.step_last) begin
            digit_mem[digit_cnt_ff[IDX_W-1:0]] <= rem_in;
            digit_cnt_ff <= digit_cnt_ff + CNT_W'(1);
            rem_ff       <= '0;
            step_cnt_ff  <= '0;
            qnz_ff       <= 1'b0;
         end else begin
            rem_ff      <= rem_in;
            step_cnt_ff <= step_cnt_ff + SC_W'(1);
            qnz_ff      <= qnz_ff || (|qbits);
         end
      end else if (cmd.emit) begin
         digit_cnt_ff <= cnt_dec;
      end
   end

   // registered read of the digit store
   always_ff @(posedge clock) begin
      mem_q_ff <= digit_mem[rd_addr];
   end

   // two-stage output pipe: read stage, then character register
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         rsp_strobe  <= 1'b0;
      end else begin
         p1_valid_ff <= cmd.sign || cmd.emit;
         rsp_strobe  <= p1_valid_ff;
      end
      p1_sign_ff    <= cmd.sign;
      p1_last_ff    <= cmd.emit && status.emit_last;
      rsp_character <= p1_sign_ff ? CHAR_MINUS : digit_char(mem_q_ff, upper_ff);
      rsp_last      <= p1_last_ff;
   end

endmodule

`default_nettype wire
